>>> src/isoline_cell_segment_extractor_assert.svh
// Assertion macros used by the extractor's top-level RTL.
`ifndef ISOLINE_CELL_SEGMENT_EXTRACTOR_ASSERT_SVH
`define ISOLINE_CELL_SEGMENT_EXTRACTOR_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define ICSE_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ICSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/icse_pkg.sv
// ----------------------------------------------------------------------------
// icse_pkg
// Types, constants and helper functions of the isoline cell segment extractor.
// ----------------------------------------------------------------------------
package icse_pkg;

	localparam int MAX_CELLS   = 4096;
	localparam int HEIGHT_BITS = 16;
	localparam int LVL_W       = 24;
	localparam int LEN_W       = 16;
	localparam int COORD_W     = 28;
	localparam int DIV_STEPS   = LEN_W;
	localparam int Q_DEPTH     = 4;
	localparam int Q_AW        = $clog2(Q_DEPTH);

	localparam logic [11:0] LAST_CELL = 12'(MAX_CELLS - 1);

	localparam logic [3:0] CASE_NONE_LO  = 4'd0;
	localparam logic [3:0] CASE_NONE_HI  = 4'd15;
	localparam logic [3:0] CASE_SADDLE_A = 4'd5;
	localparam logic [3:0] CASE_SADDLE_B = 4'd10;

	// Register byte addresses on the configuration port.
	localparam logic [3:0] ADDR_LEVEL  = 4'h0;
	localparam logic [3:0] ADDR_WIDTH  = 4'h4;
	localparam logic [3:0] ADDR_HEIGHT = 4'h8;

	typedef enum logic [1:0] {PT_B = 2'd0, PT_R = 2'd1, PT_T = 2'd2, PT_L = 2'd3} pt_e;

	// Per case code: first segment start/end, then second segment start/end.
	localparam logic [7:0] SEG_TABLE [16] = '{
		8'h00,
		{PT_L, PT_B, PT_B, PT_B},
		{PT_B, PT_R, PT_B, PT_B},
		{PT_L, PT_R, PT_B, PT_B},
		{PT_R, PT_T, PT_B, PT_B},
		{PT_R, PT_B, PT_L, PT_T},
		{PT_B, PT_T, PT_B, PT_B},
		{PT_L, PT_T, PT_B, PT_B},
		{PT_T, PT_L, PT_B, PT_B},
		{PT_T, PT_B, PT_B, PT_B},
		{PT_B, PT_L, PT_T, PT_R},
		{PT_T, PT_R, PT_B, PT_B},
		{PT_R, PT_L, PT_B, PT_B},
		{PT_R, PT_B, PT_B, PT_B},
		{PT_B, PT_L, PT_B, PT_B},
		8'h00
	};

	typedef struct packed {
		logic [15:0] corner_bottom_left;
		logic [15:0] corner_bottom_right;
		logic [15:0] corner_top_right;
		logic [15:0] corner_top_left;
		logic [11:0] cell_col;
		logic [11:0] cell_row;
	} cell_in_t;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [3:0]         case_code;
		logic               last_segment;
	} seg_out_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [LEN_W-1:0] width;
		logic [LEN_W-1:0] height;
	} cfg_t;

	// One edge lane of the restoring divider.
	typedef struct packed {
		logic [LVL_W-1:0] rem;
		logic [LEN_W-1:0] lo;
		logic [LEN_W-1:0] quo;
		logic [LVL_W-1:0] den;
		logic             sat;
		logic             zero;
	} lane_t;

	typedef struct packed {
		logic [3:0]         code;
		logic [COORD_W-1:0] ox;
		logic [COORD_W-1:0] oy;
		lane_t [3:0]        lane;
	} stage_t;

	// What the back end needs for one cell.
	typedef struct packed {
		logic [3:0]             code;
		logic [COORD_W-1:0]     ox;
		logic [COORD_W-1:0]     oy;
		logic [3:0][LEN_W-1:0]  off;
	} q_item_t;

	// One quotient bit of the restoring division.
	function automatic lane_t div_step(lane_t l);
		lane_t            n;
		logic [LVL_W:0]   r2;
		logic [LVL_W:0]   diff;
		n    = l;
		r2   = {l.rem, l.lo[LEN_W-1]};
		diff = r2 - {1'b0, l.den};
		n.lo = {l.lo[LEN_W-2:0], 1'b0};
		if (r2 >= {1'b0, l.den}) begin
			n.rem = diff[LVL_W-1:0];
			n.quo = {l.quo[LEN_W-2:0], 1'b1};
		end else begin
			n.rem = r2[LVL_W-1:0];
			n.quo = {l.quo[LEN_W-2:0], 1'b0};
		end
		return n;
	endfunction

	// Advances every lane of one divider stage by a quotient bit.
	function automatic stage_t stage_step(stage_t s);
		stage_t n;
		n = s;
		for (int e = 0; e < 4; e++) n.lane[e] = div_step(s.lane[e]);
		return n;
	endfunction

endpackage

>>> src/icse_front.sv
// ----------------------------------------------------------------------------
// icse_front
// Accepts cells, classifies corners and interpolates the crossing offset on each
// cell edge in a pipelined restoring divider.
// ----------------------------------------------------------------------------
module icse_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  icse_pkg::cell_in_t sample,
	input  icse_pkg::cfg_t    cfg,
	input  logic              en,
	output logic              push,
	output icse_pkg::q_item_t item
);
	import icse_pkg::*;

	logic                       take;
	logic [3:0]                 code;
	logic [3:0][LVL_W-1:0]      num;
	logic [3:0][LVL_W-1:0]      den;
	logic [3:0][LVL_W-1:0]      a_v;
	logic [3:0][LVL_W-1:0]      b_v;
	logic [LVL_W-1:0]           h_bl, h_br, h_tr, h_tl;

	logic                       v_s1;
	logic [3:0]                 code_s1;
	logic [11:0]                col_s1, row_s1;
	logic [3:0][LVL_W-1:0]      num_s1, den_s1;

	logic [3:0][LEN_W-1:0]      len;
	stage_t                     fill;
	logic [LVL_W+LEN_W-1:0]     prod [4];

	logic                       vld_q [DIV_STEPS+1];
	stage_t                     stg_q [DIV_STEPS+1];

	assign busy = !en;

	always_comb begin
		h_bl = {sample.corner_bottom_left[HEIGHT_BITS-1:0], 8'h00};
		h_br = {sample.corner_bottom_right[HEIGHT_BITS-1:0], 8'h00};
		h_tr = {sample.corner_top_right[HEIGHT_BITS-1:0], 8'h00};
		h_tl = {sample.corner_top_left[HEIGHT_BITS-1:0], 8'h00};
		code = {h_tl >= cfg.level, h_tr >= cfg.level, h_br >= cfg.level, h_bl >= cfg.level};
		// Edges bottom, right, top, left, each from its first corner.
		a_v = {h_bl, h_tl, h_br, h_bl};
		b_v = {h_tl, h_tr, h_tr, h_br};
		for (int e = 0; e < 4; e++) begin
			num[e] = (cfg.level >= a_v[e]) ? cfg.level - a_v[e] : a_v[e] - cfg.level;
			den[e] = (b_v[e] >= a_v[e]) ? b_v[e] - a_v[e] : a_v[e] - b_v[e];
		end
		take = start && en && sample.cell_col < LAST_CELL && sample.cell_row < LAST_CELL
			&& code != CASE_NONE_LO && code != CASE_NONE_HI;
	end

	always_comb begin
		len       = {cfg.height, cfg.width, cfg.height, cfg.width};
		fill.code = code_s1;
		fill.ox   = COORD_W'(col_s1) * COORD_W'(cfg.width);
		fill.oy   = COORD_W'(row_s1) * COORD_W'(cfg.height);
		for (int e = 0; e < 4; e++) begin
			prod[e]           = (LVL_W+LEN_W)'(num_s1[e]) * (LVL_W+LEN_W)'(len[e]);
			fill.lane[e].rem  = prod[e][LVL_W+LEN_W-1:LEN_W];
			fill.lane[e].lo   = prod[e][LEN_W-1:0];
			fill.lane[e].quo  = '0;
			fill.lane[e].den  = den_s1[e];
			fill.lane[e].sat  = num_s1[e] >= den_s1[e];
			fill.lane[e].zero = den_s1[e] == '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int k = 0; k <= DIV_STEPS; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			v_s1     <= take;
			vld_q[0] <= v_s1;
			for (int k = 1; k <= DIV_STEPS; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s1  <= code;
			col_s1   <= sample.cell_col;
			row_s1   <= sample.cell_row;
			num_s1   <= num;
			den_s1   <= den;
			stg_q[0] <= fill;
			for (int k = 1; k <= DIV_STEPS; k++) stg_q[k] <= stage_step(stg_q[k-1]);
		end
	end

	always_comb begin
		push      = en && vld_q[DIV_STEPS];
		item.code = stg_q[DIV_STEPS].code;
		item.ox   = stg_q[DIV_STEPS].ox;
		item.oy   = stg_q[DIV_STEPS].oy;
		for (int e = 0; e < 4; e++) begin
			if (stg_q[DIV_STEPS].lane[e].zero)     item.off[e] = '0;
			else if (stg_q[DIV_STEPS].lane[e].sat) item.off[e] = len[e];
			else                                   item.off[e] = stg_q[DIV_STEPS].lane[e].quo;
		end
	end

endmodule

>>> src/icse_queue.sv
// ----------------------------------------------------------------------------
// icse_queue
// Short FIFO of interpolated cells between the front and back ends.
// ----------------------------------------------------------------------------
module icse_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  icse_pkg::q_item_t din,
	input  logic              pop,
	output icse_pkg::q_item_t head,
	output logic              full,
	output logic              empty
);
	import icse_pkg::*;

	q_item_t         mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q, rd_q;
	logic [Q_AW:0]   cnt_q;

	assign head  = mem_q[rd_q];
	assign full  = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= din;
	end

endmodule

>>> src/icse_back.sv
// ----------------------------------------------------------------------------
// icse_back
// Turns a queued cell into one or two segments, one per cycle.
// ----------------------------------------------------------------------------
module icse_back (
	input  logic              clk,
	input  logic              arst_n,
	input  icse_pkg::q_item_t head,
	input  logic              empty,
	input  icse_pkg::cfg_t    cfg,
	output logic              pop,
	output logic              done,
	output icse_pkg::seg_out_t result
);
	import icse_pkg::*;

	logic               k_q;
	logic               done_q;
	seg_out_t           res_q;
	logic               two;
	logic               last;
	logic [7:0]         ent;
	logic [1:0]         p0, p1;
	logic [3:0][LEN_W-1:0] px, py;

	always_comb begin
		two  = head.code == CASE_SADDLE_A || head.code == CASE_SADDLE_B;
		last = !two || k_q;
		pop  = !empty && last;
		ent  = SEG_TABLE[head.code];
		p0   = k_q ? ent[3:2] : ent[7:6];
		p1   = k_q ? ent[1:0] : ent[5:4];
		px[PT_B] = head.off[PT_B];
		py[PT_B] = '0;
		px[PT_R] = cfg.width;
		py[PT_R] = head.off[PT_R];
		px[PT_T] = head.off[PT_T];
		py[PT_T] = cfg.height;
		px[PT_L] = '0;
		py[PT_L] = head.off[PT_L];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q    <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !empty;
			k_q    <= !empty && !last;
		end
	end

	always_ff @(posedge clk) begin
		if (!empty) begin
			res_q.start_x      <= head.ox + COORD_W'(px[p0]);
			res_q.start_y      <= head.oy + COORD_W'(py[p0]);
			res_q.end_x        <= head.ox + COORD_W'(px[p1]);
			res_q.end_y        <= head.oy + COORD_W'(py[p1]);
			res_q.case_code    <= head.code;
			res_q.last_segment <= last;
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

>>> src/isoline_cell_segment_extractor.sv
// ----------------------------------------------------------------------------
// isoline_cell_segment_extractor
// Marching-squares contour segments for one grid cell per transaction.
// ----------------------------------------------------------------------------
// A cell is accepted on any cycle with start high and busy low, so one cell per
// cycle can enter. Its first segment is on result with done high once it has
// passed the 18 front stages, the queue write and the output register. A saddle
// cell, with two diagonally opposite corners high, gives two segments on
// consecutive cycles, so the output side drains one segment per cycle. Results
// cannot be held off. A four-entry queue sits between the 18-stage
// interpolation pipeline and the segment emitter; busy rises while that queue
// is full and nothing leaves it, which happens only under a long run of saddle
// cells. Cells outside the grid and cells with all corners alike produce no
// segment.
module isoline_cell_segment_extractor (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  icse_pkg::cell_in_t sample,
	output logic               done,
	output icse_pkg::seg_out_t result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import icse_pkg::*;

	cfg_t    cfg_q;
	q_item_t f_item;
	q_item_t q_head;
	logic    q_push;
	logic    q_pop;
	logic    q_full;
	logic    q_empty;
	logic    en;
	logic    wr;
	logic    res_saddle;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level  <= '0;
			cfg_q.width  <= 16'd256;
			cfg_q.height <= 16'd256;
		end else if (wr) begin
			case (paddr)
				ADDR_LEVEL:  cfg_q.level  <= pwdata[LVL_W-1:0];
				ADDR_WIDTH:  cfg_q.width  <= pwdata[LEN_W-1:0];
				ADDR_HEIGHT: cfg_q.height <= pwdata[LEN_W-1:0];
				default:     ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			ADDR_LEVEL:  prdata = 32'(cfg_q.level);
			ADDR_WIDTH:  prdata = 32'(cfg_q.width);
			ADDR_HEIGHT: prdata = 32'(cfg_q.height);
			default:     prdata = '0;
		endcase
	end

	// The front pipeline advances unless the queue is full and not draining.
	assign en = !q_full || q_pop;

	icse_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sample (sample),
		.cfg    (cfg_q),
		.en     (en),
		.push   (q_push),
		.item   (f_item)
	);

	icse_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (f_item),
		.pop    (q_pop),
		.head   (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	icse_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty),
		.cfg    (cfg_q),
		.pop    (q_pop),
		.done   (done),
		.result (result)
	);

	assign res_saddle = result.case_code == CASE_SADDLE_A || result.case_code == CASE_SADDLE_B;

`include "isoline_cell_segment_extractor_assert.svh"

	`ICSE_ASSERT_NEVER(a_no_overflow, q_push && q_full && !q_pop, "queue overflow")
	`ICSE_ASSERT_NEVER(a_pair_only_saddle, done && !result.last_segment && !res_saddle, "non-saddle pair")
	`ICSE_ASSERT_NEXT(a_pair_follows, done && !result.last_segment, done && result.last_segment, "saddle second segment missing")

endmodule

>>> bench/isoline_cell_segment_extractor_tb.sv
// ----------------------------------------------------------------------------
// isoline_cell_segment_extractor_tb
// Self-checking bench: drives cells through the command handshake, predicts
// the contour segments of each cell and compares every strobed segment.
// ----------------------------------------------------------------------------
module isoline_cell_segment_extractor_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import icse_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 40;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	cell_in_t           sample;
	logic               done;
	seg_out_t           result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [3:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	// Shadow copy of the configuration registers.
	logic [LVL_W-1:0]   level_q;
	logic [LEN_W-1:0]   width_q;
	logic [LEN_W-1:0]   height_q;

	seg_out_t           pending_segs[$];
	int                 error_count;
	int                 seg_count;
	int                 cell_count;
	int                 idle_cycles;
	bit                 timed_out;

	isoline_cell_segment_extractor u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.sample  (sample),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [LEN_W-1:0] crossing_offset(logic [LEN_W-1:0] len,
			logic [15:0] h0, logic [15:0] h1);
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] r;
		a   = {40'd0, h0, 8'd0};
		b   = {40'd0, h1, 8'd0};
		num = (64'(level_q) >= a) ? (64'(level_q) - a) : (a - 64'(level_q));
		den = (b >= a) ? (b - a) : (a - b);
		if (den == 0)
			return '0;
		r = (num * 64'(len)) / den;
		if (r > 64'(len))
			r = 64'(len);
		return r[LEN_W-1:0];
	endfunction

	// Computes the segments a cell produces and queues them for checking.
	task automatic predict_segments(cell_in_t c);
		logic [3:0]        code;
		logic [63:0]       px[4];
		logic [63:0]       py[4];
		logic [63:0]       ox;
		logic [63:0]       oy;
		logic [7:0]        pairs;
		int                nseg;
		pt_e               p0;
		pt_e               p1;
		seg_out_t          s;
		if (c.cell_col >= LAST_CELL || c.cell_row >= LAST_CELL)
			return;
		code[0] = ({c.corner_bottom_left, 8'd0} >= level_q);
		code[1] = ({c.corner_bottom_right, 8'd0} >= level_q);
		code[2] = ({c.corner_top_right, 8'd0} >= level_q);
		code[3] = ({c.corner_top_left, 8'd0} >= level_q);
		if (code == CASE_NONE_LO || code == CASE_NONE_HI)
			return;
		nseg = (code == CASE_SADDLE_A || code == CASE_SADDLE_B) ? 2 : 1;
		px[PT_B] = 64'(crossing_offset(width_q, c.corner_bottom_left, c.corner_bottom_right));
		py[PT_B] = '0;
		px[PT_R] = 64'(width_q);
		py[PT_R] = 64'(crossing_offset(height_q, c.corner_bottom_right, c.corner_top_right));
		px[PT_T] = 64'(crossing_offset(width_q, c.corner_top_left, c.corner_top_right));
		py[PT_T] = 64'(height_q);
		px[PT_L] = '0;
		py[PT_L] = 64'(crossing_offset(height_q, c.corner_bottom_left, c.corner_top_left));
		ox = 64'(c.cell_col) * 64'(width_q);
		oy = 64'(c.cell_row) * 64'(height_q);
		case (code)
			4'd1:  pairs = {PT_L, PT_B, PT_B, PT_B};
			4'd2:  pairs = {PT_B, PT_R, PT_B, PT_B};
			4'd3:  pairs = {PT_L, PT_R, PT_B, PT_B};
			4'd4:  pairs = {PT_R, PT_T, PT_B, PT_B};
			4'd5:  pairs = {PT_R, PT_B, PT_L, PT_T};
			4'd6:  pairs = {PT_B, PT_T, PT_B, PT_B};
			4'd7:  pairs = {PT_L, PT_T, PT_B, PT_B};
			4'd8:  pairs = {PT_T, PT_L, PT_B, PT_B};
			4'd9:  pairs = {PT_T, PT_B, PT_B, PT_B};
			4'd10: pairs = {PT_B, PT_L, PT_T, PT_R};
			4'd11: pairs = {PT_T, PT_R, PT_B, PT_B};
			4'd12: pairs = {PT_R, PT_L, PT_B, PT_B};
			4'd13: pairs = {PT_R, PT_B, PT_B, PT_B};
			default: pairs = {PT_B, PT_L, PT_B, PT_B};
		endcase
		for (int k = 0; k < nseg; k++) begin
			p0 = pt_e'(pairs[7 - 4*k -: 2]);
			p1 = pt_e'(pairs[5 - 4*k -: 2]);
			s.start_x      = COORD_W'(ox + px[p0]);
			s.start_y      = COORD_W'(oy + py[p0]);
			s.end_x        = COORD_W'(ox + px[p1]);
			s.end_y        = COORD_W'(oy + py[p1]);
			s.case_code    = code;
			s.last_segment = (k + 1 == nseg);
			pending_segs   = {pending_segs, s};
		end
	endtask

	function automatic int gap_length();
		return ($urandom_range(0, 9) < 6) ? 0 :
			($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3)) :
			int'($urandom_range(8, 30));
	endfunction

	// With no gap, start stays high so the next cell follows back to back.
	task automatic send_cell(cell_in_t c);
		int n;
		start  <= 1'b1;
		sample <= c;
		do @(posedge clk); while (busy);
		predict_segments(c);
		cell_count++;
		n = gap_length();
		if (n != 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic write_register(logic [3:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (addr)
			ADDR_LEVEL: level_q  = data[LVL_W-1:0];
			ADDR_WIDTH: width_q  = data[LEN_W-1:0];
			default:    height_q = data[LEN_W-1:0];
		endcase
		@(posedge clk);
	endtask

	// Waits for the pipeline to empty so the registers may change.
	task automatic settle();
		start <= 1'b0;
		while (pending_segs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [23:0] lvl, logic [15:0] w, logic [15:0] h);
		settle();
		write_register(ADDR_LEVEL, {8'd0, lvl});
		write_register(ADDR_WIDTH, {16'd0, w});
		write_register(ADDR_HEIGHT, {16'd0, h});
	endtask

	function automatic cell_in_t make_cell(logic [15:0] bl, logic [15:0] br,
			logic [15:0] tr, logic [15:0] tl, logic [11:0] col, logic [11:0] row);
		cell_in_t c;
		c = '{bl, br, tr, tl, col, row};
		return c;
	endfunction

	// Height near the level so that the corner case is well mixed.
	function automatic logic [15:0] near_level_height();
		int base;
		base = int'(level_q >> 8);
		if ($urandom_range(0, 7) == 0)
			return 16'($urandom);
		return 16'(base + $urandom_range(0, 64) - 32);
	endfunction

	task automatic test_directed();
		configure(24'(256 * 100), 16'd256, 16'd256);
		for (int code = 0; code < 16; code++)
			send_cell(make_cell(code[0] ? 16'd150 : 16'd50, code[1] ? 16'd180 : 16'd20,
				code[2] ? 16'd120 : 16'd70, code[3] ? 16'd200 : 16'd0,
				12'(code), 12'(3 * code)));
		send_cell(make_cell(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 12'd4094, 12'd1));
		send_cell(make_cell(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 12'd4093, 12'd4093));
		send_cell(make_cell(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 12'd4095, 12'd4095));
		send_cell(make_cell(16'd100, 16'd99, 16'd99, 16'd99, 12'd0, 12'd0));
		configure(24'hFFFFFF, 16'hFFFF, 16'hFFFF);
		send_cell(make_cell(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd7, 12'd7));
		configure(24'd0, 16'hFFFF, 16'd1);
		send_cell(make_cell(16'd0, 16'd0, 16'd0, 16'd0, 12'd4093, 12'd4093));
		configure(24'h00FF80, 16'd0, 16'd0);
		send_cell(make_cell(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 12'd10, 12'd20));
	endtask

	task automatic test_random(int count);
		cell_in_t c;
		for (int i = 0; i < count; i++) begin
			c = make_cell(near_level_height(), near_level_height(), near_level_height(),
				near_level_height(), 12'($urandom), 12'($urandom));
			if ($urandom_range(0, 9) < 8) begin
				c.cell_col = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(4080, 4095)) :
					12'($urandom_range(0, 4094));
				c.cell_row = 12'($urandom_range(0, 4094));
			end
			send_cell(c);
		end
	endtask

	task automatic test_configurations();
		configure(24'($urandom_range(0, 1 << 24)), 16'($urandom_range(1, 65535)),
			16'($urandom_range(1, 65535)));
		test_random(400);
		configure(24'($urandom_range(0, 4000)), 16'd1, 16'($urandom_range(1, 600)));
		test_random(400);
		configure(24'($urandom), 16'hFFFF, 16'hFFFF);
		test_random(300);
		configure(24'($urandom), 16'($urandom), 16'($urandom));
		test_random(300);
	endtask

	// Segments are strobed for one cycle and cannot be stalled.
	always @(posedge clk) begin
		seg_out_t exp_seg;
		if (arst_n && done) begin
			seg_count++;
			if (pending_segs.size() == 0) begin
				$error("unexpected segment case_code=%0d", result.case_code);
				error_count++;
			end else begin
				exp_seg = pending_segs.pop_front();
				if (result.start_x !== exp_seg.start_x) begin
					$error("start_x exp %0d got %0d", exp_seg.start_x, result.start_x);
					error_count++;
				end
				if (result.start_y !== exp_seg.start_y) begin
					$error("start_y exp %0d got %0d", exp_seg.start_y, result.start_y);
					error_count++;
				end
				if (result.end_x !== exp_seg.end_x) begin
					$error("end_x exp %0d got %0d", exp_seg.end_x, result.end_x);
					error_count++;
				end
				if (result.end_y !== exp_seg.end_y) begin
					$error("end_y exp %0d got %0d", exp_seg.end_y, result.end_y);
					error_count++;
				end
				if (result.case_code !== exp_seg.case_code) begin
					$error("case_code exp %0d got %0d", exp_seg.case_code,
						result.case_code);
					error_count++;
				end
				if (result.last_segment !== exp_seg.last_segment) begin
					$error("last_segment exp %0d got %0d", exp_seg.last_segment,
						result.last_segment);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		sample      = '0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		cell_count  = 0;
		level_q     = '0;
		width_q     = 16'd256;
		height_q    = 16'd256;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Reset values first: level zero makes every in-grid cell case 15.
		send_cell(make_cell(16'd5, 16'd0, 16'd9, 16'd1, 12'd2, 12'd2));
		test_directed();
		test_configurations();
		settle();
		$display("Covered %0d cells and %0d segments: every corner case, grid edges,",
			cell_count, seg_count);
		$display("zero and full cell sizes, and four random register settings.");
		if (error_count == 0 && pending_segs.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+src
src/icse_pkg.sv
src/icse_front.sv
src/icse_queue.sv
src/icse_back.sv
src/isoline_cell_segment_extractor.sv
bench/isoline_cell_segment_extractor_tb.sv
